### hdl/ats_pkg.sv
// ats_pkg: shared widths, reset values, register indexes, state types and
// the evaluation result word for approach_trend_door_hold.
// No dependencies.
package ats_pkg;

  localparam int AREA_W     = 17;
  localparam int ZONE_W     = 17;
  localparam int DIP_W      = 18;
  localparam int TREND_W    = 24;
  localparam int HOLDL_W    = 8;
  localparam int HCNT_W     = 9;
  localparam int COUNT_W    = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int SUM_W      = 19;

  localparam int WINDOW_LEN_DEF = 10;

  // floor(s/3) == (s * 699051) >> 21 for every s below 2^21
  localparam int              DIV3_SHIFT = 21;
  localparam int              DIV3_MUL_W = 20;
  localparam logic [DIV3_MUL_W-1:0] DIV3_MUL = 20'd699051;

  localparam logic [ZONE_W-1:0]  ZONE_LOW_RST   = 17'd9500;
  localparam logic [ZONE_W-1:0]  ZONE_HIGH_RST  = 17'd10500;
  localparam logic [DIP_W-1:0]   DIP_LIMIT_RST  = 18'd3000;
  localparam logic [TREND_W-1:0] TREND_MIN_RST  = 24'd2;
  localparam logic [HOLDL_W-1:0] HOLD_LIMIT_RST = 8'd15;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ZONE_LOW   = 3'd0,
    CFG_ZONE_HIGH  = 3'd1,
    CFG_DIP_LIMIT  = 3'd2,
    CFG_TREND_MIN  = 3'd3,
    CFG_HOLD_LIMIT = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_AVG,
    ST_EVAL,
    ST_OUT
  } top_state_e;

  typedef enum logic [1:0] {
    EV_IDLE,
    EV_WALK,
    EV_FIN,
    EV_CMP
  } ev_state_e;

  typedef struct packed {
    logic done;
    logic pass;
  } ev_res_t;

endpackage

### hdl/ats_ram.sv
// ats_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module ats_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 10,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/ats_eval.sv
// ats_eval: window test sequencer. Walks the stored window through one
// multiply-accumulate unit, then runs the dip and trend tests.
// Depends on ats_pkg; reads window data from ats_ram.
module ats_eval
  import ats_pkg::*;
#(
  parameter int WINDOW_LEN = WINDOW_LEN_DEF,
  localparam int IDX_W = $clog2(WINDOW_LEN)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [DIP_W-1:0]   dip_limit_i,
  input  logic [TREND_W-1:0] trend_min_i,
  input  logic [AREA_W-1:0]  rdata_i,
  output logic [IDX_W-1:0]   raddr_o,
  output ev_res_t            res_o
);

  localparam int X_W   = $clog2(WINDOW_LEN + 1);
  localparam int SX    = WINDOW_LEN * (WINDOW_LEN + 1) / 2;
  localparam int SXY_W = AREA_W + $clog2(SX + 1);
  localparam int SY_W  = AREA_W + X_W;
  localparam int T_W   = SXY_W + X_W;
  localparam int NUM_W = (T_W >= TREND_W) ? T_W + 1 : TREND_W + 1;
  localparam int D_W   = AREA_W + 1;

  ev_state_e state_q, state_d;

  logic [X_W-1:0]          rd_idx_q, rd_idx_d;
  logic                    dv_q, dv_d;
  logic [IDX_W-1:0]        di_q, di_d;
  logic [AREA_W-1:0]       prev_q, prev_d;
  logic signed [D_W-1:0]   dmax_q, dmax_d, dmin_q, dmin_d;
  logic [SY_W-1:0]         sy_q, sy_d;
  logic [SXY_W-1:0]        sxy_q, sxy_d;
  logic [NUM_W-1:0]        t1_q, t1_d, t2_q, t2_d;
  logic [D_W:0]            spread_q, spread_d;

  logic [X_W-1:0]          x;
  logic [SXY_W-1:0]        prod;
  logic signed [D_W-1:0]   diff;
  logic signed [NUM_W-1:0] num;

  assign x    = X_W'(di_q) + X_W'(1);
  assign prod = SXY_W'(x) * SXY_W'(rdata_i);
  assign diff = $signed({1'b0, rdata_i}) - $signed({1'b0, prev_q});
  assign num  = $signed(t1_q - t2_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      EV_IDLE: if (start_i) state_d = EV_WALK;
      EV_WALK: if (dv_q && (di_q == IDX_W'(WINDOW_LEN - 1))) state_d = EV_FIN;
      EV_FIN:  state_d = EV_CMP;
      EV_CMP:  state_d = EV_IDLE;
      default: state_d = EV_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    raddr_o    = rd_idx_q[IDX_W-1:0];
    res_o.done = (state_q == EV_CMP);
    res_o.pass = (spread_q <= (D_W + 1)'(dip_limit_i)) &&
                 (num > $signed(NUM_W'(trend_min_i)));
  end

  // datapath
  always_comb begin
    rd_idx_d = rd_idx_q;
    dv_d     = 1'b0;
    di_d     = di_q;
    prev_d   = prev_q;
    dmax_d   = dmax_q;
    dmin_d   = dmin_q;
    sy_d     = sy_q;
    sxy_d    = sxy_q;
    t1_d     = t1_q;
    t2_d     = t2_q;
    spread_d = spread_q;
    unique case (state_q)
      EV_IDLE: begin
        rd_idx_d = '0;
      end
      EV_WALK: begin
        if (rd_idx_q != X_W'(WINDOW_LEN)) begin
          rd_idx_d = rd_idx_q + X_W'(1);
          dv_d     = 1'b1;
          di_d     = rd_idx_q[IDX_W-1:0];
        end
        if (dv_q) begin
          prev_d = rdata_i;
          if (di_q == '0) begin
            sy_d  = SY_W'(rdata_i);
            sxy_d = prod;
          end else begin
            sy_d  = sy_q + SY_W'(rdata_i);
            sxy_d = sxy_q + prod;
            if (di_q == IDX_W'(1)) begin
              dmax_d = diff;
              dmin_d = diff;
            end else begin
              if (diff > dmax_q) dmax_d = diff;
              if (diff < dmin_q) dmin_d = diff;
            end
          end
        end
      end
      EV_FIN: begin
        t1_d     = NUM_W'(sxy_q) * NUM_W'(WINDOW_LEN);
        t2_d     = NUM_W'(sy_q) * NUM_W'(SX);
        spread_d = $unsigned({dmax_q[D_W-1], dmax_q} - {dmin_q[D_W-1], dmin_q});
      end
      EV_CMP: begin
        rd_idx_d = '0;
      end
      default: begin
        rd_idx_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= EV_IDLE;
      rd_idx_q <= '0;
      dv_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_idx_q <= rd_idx_d;
      dv_q     <= dv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    di_q     <= di_d;
    prev_q   <= prev_d;
    dmax_q   <= dmax_d;
    dmin_q   <= dmin_d;
    sy_q     <= sy_d;
    sxy_q    <= sxy_d;
    t1_q     <= t1_d;
    t2_q     <= t2_d;
    spread_q <= spread_d;
  end

endmodule

### hdl/approach_trend_door_hold.sv
// approach_trend_door_hold: top level. Smoothing, window control, hold
// timer, configuration registers and the output register.
// Depends on ats_pkg, ats_ram and ats_eval.
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+--------------------------------
//  in      | in        | in_valid_i / in_stall_o  | sample_area_i
//  out     | out       | out_valid_o / out_stall_i| smoothed_area_o, window_open_o,
//          |           |                          | window_count_o, door_hold_o
//  cfg     | in        | cfg_we_i                 | cfg_index_i, cfg_data_i
//
// An ordinary word passes through ST_AVG and ST_OUT to the output register;
// the word that closes a window also passes through ST_EVAL, where ats_eval
// walks the window through its single multiply-accumulate unit.
// One word is in work at a time; in_stall_o is high until it reaches the
// output register. The output register lets the next word in while a result
// waits under out_stall_i. Reset clears history, window and hold, and loads
// the configuration registers with their reset values.
module approach_trend_door_hold
  import ats_pkg::*;
#(
  parameter int WINDOW_LEN = WINDOW_LEN_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [AREA_W-1:0]     sample_area_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [AREA_W-1:0]     smoothed_area_o,
  output logic                  window_open_o,
  output logic [COUNT_W-1:0]    window_count_o,
  output logic                  door_hold_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int IDX_W  = $clog2(WINDOW_LEN);
  localparam int PROD_W = SUM_W + DIV3_MUL_W;

  top_state_e state_q, state_d;

  logic [ZONE_W-1:0]  zone_low_q, zone_high_q;
  logic [DIP_W-1:0]   dip_limit_q;
  logic [TREND_W-1:0] trend_min_q;
  logic [HOLDL_W-1:0] hold_limit_q;

  logic [AREA_W-1:0]  p1_q, p1_d, p2_q, p2_d;
  logic [SUM_W-1:0]   sum_q, sum_d;
  logic [AREA_W-1:0]  avg_q, avg_d;
  logic [IDX_W-1:0]   fill_q, fill_d;
  logic               win_q, win_d;
  logic               hold_q, hold_d;
  logic [HCNT_W-1:0]  hcnt_q, hcnt_d;

  logic               out_valid_q, out_valid_d;
  logic [AREA_W-1:0]  out_area_q;
  logic               out_win_q, out_hold_q;
  logic [COUNT_W-1:0] out_count_q;
  logic               out_load;

  logic [PROD_W-1:0]  prod;
  logic               in_zone;
  logic               closing;
  logic               ram_we;
  logic [IDX_W-1:0]   raddr;
  logic [AREA_W-1:0]  rdata;
  ev_res_t            ev_res;
  logic [31:0]        fill_ext;

  logic in_acc;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  assign prod    = PROD_W'(sum_q) * PROD_W'(DIV3_MUL);
  assign avg_d   = prod[DIV3_SHIFT +: AREA_W];
  assign in_zone = (zone_low_q < avg_d) && (avg_d < zone_high_q);
  assign closing = (state_q == ST_AVG) && !hold_q && (fill_q != '0) &&
                   (fill_q == IDX_W'(WINDOW_LEN - 1));
  assign ram_we  = (state_q == ST_AVG) && !hold_q && ((fill_q != '0) || in_zone);

  assign out_load = (state_q == ST_OUT) && (!out_valid_q || !out_stall_i);
  assign fill_ext = 32'(fill_q);

  ats_ram #(
    .WIDTH (AREA_W),
    .DEPTH (WINDOW_LEN)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (fill_q),
    .wdata_i (avg_d),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  ats_eval #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_eval (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (closing),
    .dip_limit_i (dip_limit_q),
    .trend_min_i (trend_min_q),
    .rdata_i     (rdata),
    .raddr_o     (raddr),
    .res_o       (ev_res)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_acc) state_d = ST_AVG;
      ST_AVG:  state_d = closing ? ST_EVAL : ST_OUT;
      ST_EVAL: if (ev_res.done) state_d = ST_OUT;
      ST_OUT:  if (out_load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // window, hold and history
  always_comb begin
    p1_d   = p1_q;
    p2_d   = p2_q;
    sum_d  = sum_q;
    fill_d = fill_q;
    win_d  = win_q;
    hold_d = hold_q;
    hcnt_d = hcnt_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          sum_d = SUM_W'(sample_area_i) + SUM_W'(p1_q) + SUM_W'(p2_q);
          p1_d  = sample_area_i;
          p2_d  = p1_q;
        end
      end
      ST_AVG: begin
        if (hold_q) begin
          if (hcnt_q > HCNT_W'(hold_limit_q)) begin
            hold_d = 1'b0;
            hcnt_d = '0;
          end else begin
            hcnt_d = hcnt_q + HCNT_W'(1);
          end
        end else if (fill_q == '0) begin
          if (in_zone) begin
            win_d  = 1'b1;
            fill_d = IDX_W'(1);
          end
        end else if (closing) begin
          win_d  = 1'b0;
          fill_d = '0;
        end else begin
          fill_d = fill_q + IDX_W'(1);
        end
      end
      ST_EVAL: begin
        if (ev_res.done && ev_res.pass) begin
          hold_d = 1'b1;
          hcnt_d = HCNT_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zone_low_q   <= ZONE_LOW_RST;
      zone_high_q  <= ZONE_HIGH_RST;
      dip_limit_q  <= DIP_LIMIT_RST;
      trend_min_q  <= TREND_MIN_RST;
      hold_limit_q <= HOLD_LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_ZONE_LOW:   zone_low_q   <= cfg_data_i[ZONE_W-1:0];
        CFG_ZONE_HIGH:  zone_high_q  <= cfg_data_i[ZONE_W-1:0];
        CFG_DIP_LIMIT:  dip_limit_q  <= cfg_data_i[DIP_W-1:0];
        CFG_TREND_MIN:  trend_min_q  <= cfg_data_i[TREND_W-1:0];
        CFG_HOLD_LIMIT: hold_limit_q <= cfg_data_i[HOLDL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      p1_q        <= '0;
      p2_q        <= '0;
      fill_q      <= '0;
      win_q       <= 1'b0;
      hold_q      <= 1'b0;
      hcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      p1_q        <= p1_d;
      p2_q        <= p2_d;
      fill_q      <= fill_d;
      win_q       <= win_d;
      hold_q      <= hold_d;
      hcnt_q      <= hcnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q <= sum_d;
    if (state_q == ST_AVG) begin
      avg_q <= avg_d;
    end
    if (out_load) begin
      out_area_q  <= avg_q;
      out_win_q   <= win_q;
      out_count_q <= fill_ext[COUNT_W-1:0];
      out_hold_q  <= hold_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign smoothed_area_o = out_area_q;
  assign window_open_o   = out_win_q;
  assign window_count_o  = out_count_q;
  assign door_hold_o     = out_hold_q;

  // open window and fill count move together
  a_win_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    win_q == (fill_q != '0))
    else $error("window flag and fill count disagree");

  a_hold_nowin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold_q |-> !win_q)
    else $error("window open during hold");

  a_hold_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold_q == (hcnt_q != '0))
    else $error("hold flag and hold count disagree");

  a_eval_closed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_AVG) && closing |=> (state_q == ST_EVAL) && !win_q && (fill_q == '0))
    else $error("window not closed on evaluation");

endmodule

### bench/approach_trend_door_hold_test.sv
// approach_trend_door_hold_test: self-checking bench for the door-hold block.
// A directed table and then phases of approach runs, each phase with its own register settings.
// Result words are checked against an in-bench predictor or a typed table word. Depends on ats_pkg.
module approach_trend_door_hold_test;
  import ats_pkg::*;

  localparam int WLEN        = WINDOW_LEN_DEF;
  localparam int AREA_MAX    = (1 << AREA_W) - 1;
  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_WORDS = 105;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 3'd7;

  typedef struct packed {
    logic [AREA_W-1:0]  smoothed;
    logic               win_open;
    logic [COUNT_W-1:0] win_count;
    logic               hold;
  } door_word_t;

  typedef struct packed {
    logic [AREA_W-1:0] area;
    logic              typed;
    door_word_t        res;
  } dir_row_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  in_valid_i    = 1'b0;
  logic                  in_stall_o;
  logic [AREA_W-1:0]     sample_area_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i   = 1'b0;
  logic [AREA_W-1:0]     smoothed_area_o;
  logic                  window_open_o;
  logic [COUNT_W-1:0]    window_count_o;
  logic                  door_hold_o;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;

  // predictor state and register copies
  logic [ZONE_W-1:0]  zone_lo     = ZONE_LOW_RST;
  logic [ZONE_W-1:0]  zone_hi     = ZONE_HIGH_RST;
  logic [DIP_W-1:0]   dip_max     = DIP_LIMIT_RST;
  logic [TREND_W-1:0] trend_floor = TREND_MIN_RST;
  logic [HOLDL_W-1:0] hold_lim    = HOLD_LIMIT_RST;
  logic [AREA_W-1:0]  raw_last    = '0;
  logic [AREA_W-1:0]  raw_older   = '0;
  logic [AREA_W-1:0]  win_buf [WLEN];
  int                 win_fill    = 0;
  logic               win_on      = 1'b0;
  logic               hold_on     = 1'b0;
  logic [HCNT_W-1:0]  hold_cnt    = '0;

  door_word_t door_words_due [$];
  dir_row_t   dir_rows [$];
  logic       typed_on   = 1'b0;
  door_word_t typed_word = '0;
  int         fail_count = 0;
  int         words_seen = 0;
  int         words_sent = 0;
  int         idle_cycles = 0;
  int         send_gap_pct = 0;
  int         recv_gap_pct = 0;
  int         hold_off_left = 0;

  approach_trend_door_hold dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .sample_area_i,
    .out_valid_o, .out_stall_i, .smoothed_area_o, .window_open_o,
    .window_count_o, .door_hold_o, .cfg_we_i, .cfg_index_i, .cfg_data_i
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic bit approach_window_passes();
    longint d, dhi, dlo, y0, y1, sx, sy, sxy, num, lim;
    int i;
    dhi = 0;
    dlo = 0;
    sx  = 0;
    sy  = 0;
    sxy = 0;
    for (i = 0; i + 1 < WLEN; i++) begin
      y0 = win_buf[i];
      y1 = win_buf[i+1];
      d  = y1 - y0;
      if (i == 0 || d > dhi) dhi = d;
      if (i == 0 || d < dlo) dlo = d;
    end
    lim = dip_max;
    if (dhi - dlo > lim) return 1'b0;
    for (i = 0; i < WLEN; i++) begin
      y0  = win_buf[i];
      sx  += i + 1;
      sy  += y0;
      sxy += (i + 1) * y0;
    end
    num = WLEN * sxy - sx * sy;
    lim = trend_floor;
    return num > lim;
  endfunction

  function automatic door_word_t predict_door_word(logic [AREA_W-1:0] raw);
    int         total;
    door_word_t w;
    total      = raw + raw_last + raw_older;
    w.smoothed = AREA_W'(total / 3);
    raw_older  = raw_last;
    raw_last   = raw;
    if (!hold_on) begin
      if (win_fill == 0) begin
        if (zone_lo < w.smoothed && w.smoothed < zone_hi) begin
          win_on     = 1'b1;
          win_buf[0] = w.smoothed;
          win_fill   = 1;
        end
      end else begin
        if (win_fill < WLEN) win_buf[win_fill] = w.smoothed;
        win_fill++;
        if (win_fill >= WLEN) begin
          win_on   = 1'b0;
          win_fill = 0;
          if (approach_window_passes()) begin
            hold_on  = 1'b1;
            hold_cnt = HCNT_W'(1);
          end
        end
      end
    end else if (hold_cnt > hold_lim) begin
      hold_on  = 1'b0;
      hold_cnt = '0;
    end else begin
      hold_cnt = hold_cnt + HCNT_W'(1);
    end
    w.win_open  = win_on;
    w.win_count = win_fill[COUNT_W-1:0];
    w.hold      = hold_on;
    return w;
  endfunction

  task automatic flag_mismatch(string field, int got, int want);
    $display("word %0d: %s is %0d, expected %0d", words_seen, field, got, want);
    fail_count++;
  endtask

  always @(posedge clk_i) begin : watch_words
    door_word_t got, due, pred;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got = {smoothed_area_o, window_open_o, window_count_o, door_hold_o};
        if (door_words_due.size() == 0) begin
          flag_mismatch("word with none due, smoothed_area", got.smoothed, 0);
        end else begin
          due = door_words_due.pop_front();
          if (got.smoothed !== due.smoothed)
            flag_mismatch("smoothed_area", got.smoothed, due.smoothed);
          if (got.win_open !== due.win_open)
            flag_mismatch("window_open", got.win_open, due.win_open);
          if (got.win_count !== due.win_count)
            flag_mismatch("window_count", got.win_count, due.win_count);
          if (got.hold !== due.hold)
            flag_mismatch("door_hold", got.hold, due.hold);
        end
        words_seen++;
      end
      if (in_valid_i && !in_stall_o) begin
        pred = predict_door_word(sample_area_i);
        door_words_due = {door_words_due, (typed_on ? typed_word : pred)};
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("FAIL approach_trend_door_hold");
      $finish;
    end
  end

  // receiver: long hold-off on request, else random stall
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_off_left > 0) begin
        out_stall_i = 1'b1;
        hold_off_left--;
      end else begin
        out_stall_i = ($urandom_range(99) < recv_gap_pct);
      end
    end
  end

  task automatic send_area(logic [AREA_W-1:0] area, logic typed, door_word_t res);
    @(negedge clk_i);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    = 1'b1;
    sample_area_i = area;
    typed_on      = typed;
    typed_word    = res;
    do @(posedge clk_i); while (in_stall_o);
    words_sent++;
  endtask

  task automatic drain_words();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (door_words_due.size() != 0) @(posedge clk_i);
  endtask

  // bits above a register's width carry junk; the block masks them
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned value);
    logic [CFG_DATA_W-1:0] junk, data;
    junk = $urandom;
    case (idx)
      CFG_ZONE_LOW, CFG_ZONE_HIGH: data = {junk[CFG_DATA_W-1:ZONE_W], value[ZONE_W-1:0]};
      CFG_DIP_LIMIT:               data = {junk[CFG_DATA_W-1:DIP_W], value[DIP_W-1:0]};
      CFG_TREND_MIN:               data = value[TREND_W-1:0];
      CFG_HOLD_LIMIT:              data = {junk[CFG_DATA_W-1:HOLDL_W], value[HOLDL_W-1:0]};
      default:                     data = junk;
    endcase
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    @(posedge clk_i);
    case (idx)
      CFG_ZONE_LOW:   zone_lo     = data[ZONE_W-1:0];
      CFG_ZONE_HIGH:  zone_hi     = data[ZONE_W-1:0];
      CFG_DIP_LIMIT:  dip_max     = data[DIP_W-1:0];
      CFG_TREND_MIN:  trend_floor = data[TREND_W-1:0];
      CFG_HOLD_LIMIT: hold_lim    = data[HOLDL_W-1:0];
      default: ;
    endcase
  endtask

  task automatic program_regs(int unsigned zl, int unsigned zh, int unsigned dip,
                              int unsigned trend, int unsigned hl);
    write_reg(CFG_ZONE_LOW, zl);
    write_reg(CFG_ZONE_HIGH, zh);
    write_reg(CFG_DIP_LIMIT, dip);
    write_reg(CFG_TREND_MIN, trend);
    write_reg(CFG_HOLD_LIMIT, hl);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // a person walking through the zone: clean line, jitter, one spike, or noise
  task automatic send_approach_run();
    int mid, slope, len, jit, kind, v, k, spike_at;
    kind     = $urandom_range(9);
    len      = $urandom_range(12, 22);
    mid      = (int'(zone_lo) + int'(zone_hi)) / 2;
    slope    = int'($urandom_range(500)) - 150;
    jit      = $urandom_range(1, 300);
    spike_at = $urandom_range(3, len - 1);
    for (k = 0; k < len; k++) begin
      if (kind == 9) begin
        v = $urandom_range(AREA_MAX);
      end else begin
        v = mid + (k - 4) * slope;
        if (kind >= 5 && kind <= 7) v += int'($urandom_range(jit)) - jit / 2;
        if (kind == 8 && k == spike_at)
          v += $urandom_range(1) ? int'($urandom_range(2000, 40000))
                                 : -int'($urandom_range(2000, 40000));
      end
      if (v < 0) v = 0;
      if (v > AREA_MAX) v = AREA_MAX;
      send_area(AREA_W'(v), 1'b0, '0);
    end
  endtask

  function automatic dir_row_t dir_row(int area, bit typed, int sm, bit op, int cnt, bit hd);
    dir_row_t r;
    r.area  = area[AREA_W-1:0];
    r.typed = typed;
    r.res   = {sm[AREA_W-1:0], op, cnt[COUNT_W-1:0], hd};
    return r;
  endfunction

  function automatic void add_row(dir_row_t r);
    dir_rows = {dir_rows, r};
  endfunction

  initial begin
    int i, phase, target, zl;
    add_row(dir_row(0,        1, 0,        0, 0, 0));
    add_row(dir_row(AREA_MAX, 1, 43690,    0, 0, 0));
    add_row(dir_row(AREA_MAX, 1, 87380,    0, 0, 0));
    add_row(dir_row(AREA_MAX, 1, AREA_MAX, 0, 0, 0));
    add_row(dir_row(76800,    0, 0,        0, 0, 0));
    add_row(dir_row(76800,    0, 0,        0, 0, 0));
    add_row(dir_row(76800,    1, 76800,    0, 0, 0));
    add_row(dir_row(9600,     0, 0,        0, 0, 0));
    add_row(dir_row(9600,     0, 0,        0, 0, 0));
    add_row(dir_row(9600,     1, 9600,     1, 1, 0));
    // steady rise fills the window and should raise door hold
    for (i = 9700; i <= 10500; i += 100) add_row(dir_row(i, 0, 0, 0, 0, 0));
    for (i = 0; i < 4; i++) add_row(dir_row(10500, 0, 0, 0, 0, 0));

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_rows[i]) send_area(dir_rows[i].area, dir_rows[i].typed, dir_rows[i].res);
    drain_words();

    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0: program_regs(ZONE_LOW_RST, ZONE_HIGH_RST, DIP_LIMIT_RST, TREND_MIN_RST,
                        HOLD_LIMIT_RST);
        1: program_regs(0, 76800, 0, 0, 1);
        2: program_regs(30000, 50000, 153600, 24'hFFFFFF, 255);
        3: program_regs(20000, 20001, 3000, 2, 3);     // empty zone
        4: program_regs(5000, 60000, 5000, 100000, 0);
        default: begin
          zl = $urandom_range(70000);
          write_reg(CFG_SPARE_IDX, $urandom);
          program_regs(zl, zl + $urandom_range(2, 6000), $urandom_range(153600),
                       $urandom_range(200000), $urandom_range(40));
        end
      endcase
      send_gap_pct = (phase < 2) ? 13 : (phase < 4) ? 49 : 0;
      recv_gap_pct = (phase < 2) ? 49 : (phase < 4) ? 13 : 0;
      if (phase == 0) hold_off_left = 80;
      target = words_sent + PHASE_WORDS;
      while (words_sent < target) begin
        if ($urandom_range(9) == 0) send_area(AREA_W'($urandom_range(AREA_MAX)), 1'b0, '0);
        else send_approach_run();
      end
      drain_words();
    end

    repeat (20) @(posedge clk_i);
    if (door_words_due.size() != 0) flag_mismatch("words never seen", 0, door_words_due.size());
    if (fail_count == 0) $display("PASS approach_trend_door_hold");
    else $display("FAIL approach_trend_door_hold");
    $finish;
  end

endmodule

### files.f
hdl/ats_pkg.sv
hdl/ats_ram.sv
hdl/ats_eval.sv
hdl/approach_trend_door_hold.sv
bench/approach_trend_door_hold_test.sv
